// ===== src/roi_gray_band_pixel_counter_macros.svh =====
// assertion macros for the roi gray band pixel counter checker
// depends on nothing; included by the checker file only
`ifndef ROI_GRAY_BAND_PIXEL_COUNTER_MACROS_SVH
`define ROI_GRAY_BAND_PIXEL_COUNTER_MACROS_SVH

// same-cycle implication, masked during reset
`define RGBPC_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rgbpc check failed");

// next-cycle implication, masked during reset
`define RGBPC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rgbpc check failed");

// next-cycle implication, always checked
`define RGBPC_ASSERT_ALWAYS_NEXT(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("rgbpc check failed");

`endif

// ===== src/rgbpc_pkg.sv =====
// shared types and constants of the roi gray band pixel counter
// depends on nothing
package rgbpc_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int LEN_W    = DIM_W + 1;
  localparam int CMP_W    = 16;
  localparam int FW_W     = 13;
  localparam int POS_W    = 12;
  localparam int EXT_W    = 13;
  localparam int PIX_W    = 8;
  localparam int CNT_W    = 25;
  localparam int LUMA_W   = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(16777216);
  localparam logic [LUMA_W-1:0] COEF_B     = LUMA_W'(1868);
  localparam logic [LUMA_W-1:0] COEF_G     = LUMA_W'(9617);
  localparam logic [LUMA_W-1:0] COEF_R     = LUMA_W'(4899);
  localparam logic [LUMA_W-1:0] LUMA_ROUND = LUMA_W'(8192);
  localparam int LUMA_SHIFT = 14;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_ROI_LEFT    = 3'd1,
    REG_ROI_TOP     = 3'd2,
    REG_ROI_WIDTH   = 3'd3,
    REG_ROI_HEIGHT  = 3'd4,
    REG_BAND_LOW    = 3'd5,
    REG_BAND_HIGH   = 3'd6
  } cfg_reg_t;

  // geometry settings seen by the front
  typedef struct packed {
    logic [FW_W-1:0]  frame_width;
    logic [POS_W-1:0] roi_left;
    logic [POS_W-1:0] roi_top;
    logic [EXT_W-1:0] roi_width;
    logic [EXT_W-1:0] roi_height;
  } geom_cfg_t;

  // band settings seen by the back
  typedef struct packed {
    pix_t band_low;
    pix_t band_high;
  } band_cfg_t;

  // one queued request between front and back
  typedef struct packed {
    pix_t gray;
    logic keep;
    logic last;
  } q_entry_t;

endpackage

// ===== src/rgbpc_if.sv =====
// channel interfaces of the roi gray band pixel counter
// depends on rgbpc_pkg
interface rgbpc_pix_if;
  import rgbpc_pkg::*;
  logic valid;
  logic ready;
  pix_t blue;
  pix_t green;
  pix_t red;
  logic last_in_frame;
  modport source (output valid, blue, green, red, last_in_frame, input ready);
  modport sink   (input valid, blue, green, red, last_in_frame, output ready);
endinterface

interface rgbpc_cnt_if;
  import rgbpc_pkg::*;
  logic   valid;
  logic   ready;
  count_t white_count;
  modport source (output valid, white_count, input ready);
  modport sink   (input valid, white_count, output ready);
endinterface

interface rgbpc_cfg_if;
  import rgbpc_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rgbpc_front.sv =====
// front: raster position tracking, region test and luma of each request
// depends on rgbpc_pkg and rgbpc_pix_if
module rgbpc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  rgbpc_pix_if.sink             in_pix,
  input  rgbpc_pkg::geom_cfg_t  geom,
  input  logic                  q_full,
  output logic                  push,
  output rgbpc_pkg::q_entry_t   push_entry
);
  import rgbpc_pkg::*;

  logic [DIM_W-1:0]  column_r, column_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [LEN_W-1:0]  line_len;
  logic [LEN_W-1:0]  column_inc;
  logic [LEN_W-1:0]  row_inc;
  logic              in_cols, in_rows;
  logic [LUMA_W-1:0] luma_sum;

  assign in_pix.ready = !q_full;
  assign push         = in_pix.valid && !q_full;

  // zero width acts as one, oversize clamps to the max line
  always_comb begin
    if (geom.frame_width == '0) begin
      line_len = LEN_W'(1);
    end else if (CMP_W'(geom.frame_width) > CMP_W'(MAX_DIM)) begin
      line_len = LEN_W'(MAX_DIM);
    end else begin
      line_len = LEN_W'(geom.frame_width);
    end
  end

  assign in_cols = (CMP_W'(column_r) >= CMP_W'(geom.roi_left)) &&
                   (CMP_W'(column_r) < CMP_W'(geom.roi_left) + CMP_W'(geom.roi_width));
  assign in_rows = (CMP_W'(row_r) >= CMP_W'(geom.roi_top)) &&
                   (CMP_W'(row_r) < CMP_W'(geom.roi_top) + CMP_W'(geom.roi_height));

  assign luma_sum = COEF_B * LUMA_W'(in_pix.blue) + COEF_G * LUMA_W'(in_pix.green) +
                    COEF_R * LUMA_W'(in_pix.red) + LUMA_ROUND;

  assign push_entry.gray = luma_sum[LUMA_SHIFT +: PIX_W];
  assign push_entry.keep = in_cols && in_rows;
  assign push_entry.last = in_pix.last_in_frame;

  assign column_inc = LEN_W'(column_r) + LEN_W'(1);
  assign row_inc    = LEN_W'(row_r) + LEN_W'(1);

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    if (push) begin
      if (in_pix.last_in_frame) begin
        column_nxt = '0;
        row_nxt    = '0;
      end else if (column_inc >= line_len) begin
        column_nxt = '0;
        // row holds at the last one past the max height
        if (CMP_W'(row_inc) < CMP_W'(MAX_DIM)) begin
          row_nxt = row_inc[DIM_W-1:0];
        end
      end else begin
        column_nxt = column_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ===== src/rgbpc_fifo.sv =====
// two-entry queue between front and back
// depends on rgbpc_pkg
module rgbpc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rgbpc_pkg::q_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output rgbpc_pkg::q_entry_t  head_entry
);
  import rgbpc_pkg::*;

  q_entry_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full       = (fill_r == 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== src/rgbpc_back.sv =====
// back: band test, saturating hit count and result register
// depends on rgbpc_pkg and rgbpc_cnt_if
module rgbpc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgbpc_pkg::band_cfg_t band,
  input  logic                 head_valid,
  input  rgbpc_pkg::q_entry_t  head_entry,
  output logic                 pop,
  rgbpc_cnt_if.source          out_cnt
);
  import rgbpc_pkg::*;

  count_t hit_total_r, hit_total_nxt;
  count_t total_upd;
  count_t count_r;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   hit;

  assign out_free = !out_valid_r || out_cnt.ready;
  // a frame end waits for the result register
  assign pop      = head_valid && (!head_entry.last || out_free);

  assign hit = head_entry.keep && (head_entry.gray >= band.band_low) &&
               (head_entry.gray <= band.band_high);
  assign total_upd = (hit && (hit_total_r < COUNT_MAX)) ? hit_total_r + CNT_W'(1)
                                                       : hit_total_r;

  always_comb begin
    hit_total_nxt = hit_total_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_cnt.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      if (head_entry.last) begin
        hit_total_nxt = '0;
        out_valid_nxt = 1'b1;
      end else begin
        hit_total_nxt = total_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_entry.last) begin
      count_r <= total_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hit_total_r <= hit_total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_cnt.valid       = out_valid_r;
  assign out_cnt.white_count = count_r;

endmodule

// ===== src/roi_gray_band_pixel_counter.sv =====
// top level of the roi gray band pixel counter: settings registers and wiring
// depends on rgbpc_pkg, rgbpc_if, rgbpc_front, rgbpc_fifo, rgbpc_back
//
// Counts the pixels of a raster-order BGR frame that fall inside a rectangular
// region of interest and whose luma, (1868*B + 9617*G + 4899*R + 8192) >> 14,
// lies in the inclusive band band_low..band_high. One pixel request is taken
// per clock unless the queue is full; the front works out position, region
// test and luma in the cycle the request is taken and writes it into the queue,
// and the back counts it in the cycle it leaves the queue, so the count is
// offered on out_cnt by the result register once the last_in_frame request
// has left the queue, and the next frame's pixels flow on meanwhile. The
// two-entry queue between front and back absorbs back stalls until full; a
// result held by out_cnt stalls the back only when the next frame end reaches
// it. Settings are written through cfg_wr (always ready, index beyond the
// list is dropped) and must only change while no pixel is in flight. A region
// running past the frame counts only the overlap; the count saturates at 2^24.
module roi_gray_band_pixel_counter (
  input  logic          clk,
  input  logic          rst_n,
  rgbpc_pix_if.sink     in_pix,
  rgbpc_cnt_if.source   out_cnt,
  rgbpc_cfg_if.sink     cfg_wr
);
  import rgbpc_pkg::*;

  // settings registers
  geom_cfg_t geom_r, geom_nxt;
  band_cfg_t band_r, band_nxt;

  // front to queue
  logic      q_full;
  logic      push;
  q_entry_t  push_entry;

  // queue to back
  logic      pop;
  logic      head_valid;
  q_entry_t  head_entry;

  assign cfg_wr.ready = 1'b1;

  // register write decode, data truncated to each field
  always_comb begin
    geom_nxt = geom_r;
    band_nxt = band_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_FRAME_WIDTH: geom_nxt.frame_width = cfg_wr.data[FW_W-1:0];
        REG_ROI_LEFT:    geom_nxt.roi_left    = cfg_wr.data[POS_W-1:0];
        REG_ROI_TOP:     geom_nxt.roi_top     = cfg_wr.data[POS_W-1:0];
        REG_ROI_WIDTH:   geom_nxt.roi_width   = cfg_wr.data[EXT_W-1:0];
        REG_ROI_HEIGHT:  geom_nxt.roi_height  = cfg_wr.data[EXT_W-1:0];
        REG_BAND_LOW:    band_nxt.band_low    = cfg_wr.data[PIX_W-1:0];
        REG_BAND_HIGH:   band_nxt.band_high   = cfg_wr.data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // settings come out of reset with the default region and band
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.frame_width <= FW_W'(1920);
      geom_r.roi_left    <= POS_W'(660);
      geom_r.roi_top     <= POS_W'(75);
      geom_r.roi_width   <= EXT_W'(709);
      geom_r.roi_height  <= EXT_W'(425);
      band_r.band_low    <= PIX_W'(75);
      band_r.band_high   <= PIX_W'(100);
    end else begin
      geom_r <= geom_nxt;
      band_r <= band_nxt;
    end
  end

  // position tracking, region test and luma
  rgbpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .geom       (geom_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the pixel side from the result side
  rgbpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // band test, counting and result register
  rgbpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .band       (band_r),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_cnt    (out_cnt)
  );

endmodule

// ===== src/rgbpc_chk.sv =====
// port-level checks of the roi gray band pixel counter, bound to the top level
// depends on rgbpc_pkg and roi_gray_band_pixel_counter_macros.svh
`include "roi_gray_band_pixel_counter_macros.svh"

module rgbpc_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input rgbpc_pkg::count_t white_count
);
  import rgbpc_pkg::*;

  // no result survives a reset cycle
  `RGBPC_ASSERT_ALWAYS_NEXT(a_reset_clears_out, clk, !rst_n, !out_valid)

  // a count never passes the saturation point
  `RGBPC_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, white_count <= COUNT_MAX)

  // a stalled result stays offered
  `RGBPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // and its count does not move
  `RGBPC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(white_count))

endmodule

bind roi_gray_band_pixel_counter rgbpc_chk u_rgbpc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_cnt.valid),
  .out_ready   (out_cnt.ready),
  .white_count (out_cnt.white_count)
);
